[hdl/bdd_pkg.sv]
// bdd_pkg: shared types, constants and the calibration remainder table
// for the baseline deviation detector; no dependencies
package bdd_pkg;

    localparam int SAMPLE_W    = 13;
    localparam int BASE_W      = 29;
    localparam int FRAC_W      = 16;
    localparam int SUM_W       = 19;
    localparam int COUNT_W     = 6;
    localparam int WEIGHT_W    = 17;
    localparam int THRESH_W    = 12;
    localparam int PERIOD_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [COUNT_W-1:0] CAL_SAMPLES = 6'd50;

    // floor(sum * 65536 / 50) == floor(sum * 32768 / 25)
    localparam int CAL_DIV       = 25;
    localparam int CAL_FRAC_W    = 15;
    localparam int CAL_BIAS_Q    = 8192;
    localparam int CAL_BIAS      = CAL_DIV * CAL_BIAS_Q;
    localparam int DIV_IN_W      = 20;
    localparam int DIV_SHIFT     = 24;
    localparam int DIV_RECIP     = ((1 << DIV_SHIFT) + CAL_DIV - 1) / CAL_DIV;
    localparam int DIV_Q_W       = 16;
    localparam int REM_W         = 5;

    localparam logic signed [BASE_W+2:0] BASE_MAX = 32'sd268435455;
    localparam logic signed [BASE_W+2:0] BASE_MIN = -32'sd268435456;

    typedef enum logic [1:0] {
        ACT_CALIBRATE = 2'd0,
        ACT_TICK      = 2'd1,
        ACT_QUERY     = 2'd2
    } action_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_EMA_WEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD     = 2'd2;

    // floor(r * 32768 / 25) for remainders 0..24
    function automatic logic [CAL_FRAC_W-1:0] cal_frac(input logic [REM_W-1:0] r);
        logic [CAL_FRAC_W-1:0] v;
        unique case (r)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd1310;
            5'd2:    v = 15'd2621;
            5'd3:    v = 15'd3932;
            5'd4:    v = 15'd5242;
            5'd5:    v = 15'd6553;
            5'd6:    v = 15'd7864;
            5'd7:    v = 15'd9175;
            5'd8:    v = 15'd10485;
            5'd9:    v = 15'd11796;
            5'd10:   v = 15'd13107;
            5'd11:   v = 15'd14417;
            5'd12:   v = 15'd15728;
            5'd13:   v = 15'd17039;
            5'd14:   v = 15'd18350;
            5'd15:   v = 15'd19660;
            5'd16:   v = 15'd20971;
            5'd17:   v = 15'd22282;
            5'd18:   v = 15'd23592;
            5'd19:   v = 15'd24903;
            5'd20:   v = 15'd26214;
            5'd21:   v = 15'd27525;
            5'd22:   v = 15'd28835;
            5'd23:   v = 15'd30146;
            5'd24:   v = 15'd31457;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/baseline_deviation_detector.sv]
// baseline_deviation_detector: top level, registers, handshakes and datapath
// depends on bdd_pkg and bdd_cal_div
//
// Takes one transaction per clock unless the output side stalls, and returns
// one result per transaction: the item sits in an input register, then logic
// (the calibration reciprocal multiply or the 30x18 smoothing multiply)
// updates the state and loads the result register. in_ready follows out_ready
// through that result register. Baseline is held in signed Q13.16;
// baseline_whole is its floor. Registers must be written through
// cfg_write/cfg_index/cfg_data only while no transaction is in flight
// (not enforced); index 0 ema_weight, 1 deviation_threshold, 2 sample_period
module baseline_deviation_detector (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [bdd_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [bdd_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             action,
    input  logic signed [bdd_pkg::SAMPLE_W-1:0]    sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   present,
    output logic                                   calibrated,
    output logic signed [bdd_pkg::SAMPLE_W-1:0]    baseline_whole
);
    import bdd_pkg::*;

    logic [WEIGHT_W-1:0]          ema_weight_reg;
    logic [THRESH_W-1:0]          threshold_reg;
    logic [PERIOD_W-1:0]          period_reg;

    logic                         s1_valid_reg;
    logic [1:0]                   s1_action_reg;
    logic signed [SAMPLE_W-1:0]   s1_sample_reg;

    logic signed [SUM_W-1:0]      cal_sum_reg,      cal_sum_next;
    logic [COUNT_W-1:0]           cal_count_reg,    cal_count_next;
    logic signed [BASE_W-1:0]     baseline_reg,     baseline_next;
    logic                         is_cal_reg,       is_cal_next;
    logic [PERIOD_W-1:0]          period_count_reg, period_count_next;

    logic                         out_valid_reg;
    logic                         present_reg,      present_next;
    logic                         calibrated_reg;
    logic signed [SAMPLE_W-1:0]   baseline_whole_reg;

    logic                         advance;
    logic                         fire;

    logic signed [BASE_W-1:0]     sample_q;
    logic signed [BASE_W:0]       diff;
    logic signed [BASE_W+WEIGHT_W+1:0] prod;
    logic signed [BASE_W+2:0]     step;
    logic signed [BASE_W+2:0]     ema_sum;
    logic signed [BASE_W-1:0]     ema_base;
    logic signed [BASE_W:0]       thresh_q;
    logic                         outside;
    logic [PERIOD_W:0]            period_inc;
    logic                         period_hit;
    logic signed [SUM_W-1:0]      cal_sum_start;
    logic [COUNT_W-1:0]           cal_count_start;
    logic signed [SUM_W-1:0]      cal_sum_new;
    logic [COUNT_W-1:0]           cal_count_new;
    logic signed [BASE_W-1:0]     cal_avg;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;

    assign out_valid      = out_valid_reg;
    assign present        = present_reg;
    assign calibrated     = calibrated_reg;
    assign baseline_whole = baseline_whole_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ema_weight_reg <= WEIGHT_W'(6554);
            threshold_reg  <= THRESH_W'(50);
            period_reg     <= PERIOD_W'(100);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_EMA_WEIGHT: ema_weight_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_THRESHOLD:  threshold_reg  <= cfg_data[THRESH_W-1:0];
                CFG_PERIOD:     period_reg     <= cfg_data[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_action_reg <= action;
            s1_sample_reg <= sample;
        end
    end

    // smoothing update and deviation test
    assign sample_q   = {s1_sample_reg, {FRAC_W{1'b0}}};
    assign diff       = (BASE_W+1)'(sample_q) - (BASE_W+1)'(baseline_reg);
    assign prod       = (BASE_W+WEIGHT_W+2)'(diff)
                      * (BASE_W+WEIGHT_W+2)'($signed({1'b0, ema_weight_reg}));
    assign step       = prod[FRAC_W +: BASE_W+3];
    assign ema_sum    = (BASE_W+3)'(baseline_reg) + step;
    assign thresh_q   = $signed({2'b00, threshold_reg, {FRAC_W{1'b0}}});
    assign outside    = (diff > thresh_q) || (diff < -thresh_q);
    assign period_inc = {1'b0, period_count_reg} + (PERIOD_W+1)'(1);
    assign period_hit = period_inc >= {1'b0, period_reg};

    always_comb
    begin
        if (ema_sum > BASE_MAX)
        begin
            ema_base = BASE_MAX[BASE_W-1:0];
        end
        else if (ema_sum < BASE_MIN)
        begin
            ema_base = BASE_MIN[BASE_W-1:0];
        end
        else
        begin
            ema_base = ema_sum[BASE_W-1:0];
        end
    end

    // calibration accumulate, recalibration restarts from zero
    assign cal_sum_start   = is_cal_reg ? '0 : cal_sum_reg;
    assign cal_count_start = is_cal_reg ? '0 : cal_count_reg;
    assign cal_sum_new     = cal_sum_start + SUM_W'(s1_sample_reg);
    assign cal_count_new   = cal_count_start + COUNT_W'(1);

    bdd_cal_div u_cal_div (
        .sum (cal_sum_new),
        .avg (cal_avg)
    );

    always_comb
    begin
        cal_sum_next      = cal_sum_reg;
        cal_count_next    = cal_count_reg;
        baseline_next     = baseline_reg;
        is_cal_next       = is_cal_reg;
        period_count_next = period_count_reg;
        present_next      = 1'b0;
        unique case (s1_action_reg)
            ACT_CALIBRATE:
            begin
                if (cal_count_new >= CAL_SAMPLES)
                begin
                    baseline_next     = cal_avg;
                    is_cal_next       = 1'b1;
                    period_count_next = '0;
                    cal_sum_next      = '0;
                    cal_count_next    = '0;
                end
                else
                begin
                    is_cal_next    = 1'b0;
                    cal_sum_next   = cal_sum_new;
                    cal_count_next = cal_count_new;
                end
            end
            ACT_TICK:
            begin
                if (is_cal_reg)
                begin
                    if (period_hit)
                    begin
                        baseline_next     = ema_base;
                        period_count_next = '0;
                    end
                    else
                    begin
                        period_count_next = period_inc[PERIOD_W-1:0];
                    end
                end
            end
            ACT_QUERY:
            begin
                present_next = is_cal_reg && outside;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_sum_reg      <= '0;
            cal_count_reg    <= '0;
            baseline_reg     <= '0;
            is_cal_reg       <= 1'b0;
            period_count_reg <= '0;
        end
        else if (fire)
        begin
            cal_sum_reg      <= cal_sum_next;
            cal_count_reg    <= cal_count_next;
            baseline_reg     <= baseline_next;
            is_cal_reg       <= is_cal_next;
            period_count_reg <= period_count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            present_reg        <= present_next;
            calibrated_reg     <= is_cal_next;
            baseline_whole_reg <= baseline_next[BASE_W-1 -: SAMPLE_W];
        end
    end

endmodule

[hdl/bdd_cal_div.sv]
// bdd_cal_div: calibration average, floor(sum * 65536 / 50) in Q13.16
// reciprocal multiply by 1/25 plus remainder table; depends on bdd_pkg
module bdd_cal_div (
    input  logic signed [bdd_pkg::SUM_W-1:0]  sum,
    output logic signed [bdd_pkg::BASE_W-1:0] avg
);
    import bdd_pkg::*;

    logic signed [DIV_IN_W-1:0]   sum_ext;
    logic [DIV_IN_W-1:0]          biased;
    logic [2*DIV_IN_W-1:0]        prod;
    logic [DIV_Q_W-1:0]           quot;
    logic [DIV_IN_W-1:0]          rem_full;
    logic signed [DIV_Q_W:0]      whole;
    logic [BASE_W+2:0]            avg_wide;

    // bias keeps the dividend non-negative so the reciprocal floors correctly
    assign sum_ext  = DIV_IN_W'(sum);
    assign biased   = DIV_IN_W'(sum_ext) + DIV_IN_W'(CAL_BIAS);
    assign prod     = (2*DIV_IN_W)'(biased) * (2*DIV_IN_W)'(DIV_RECIP);
    assign quot     = prod[DIV_SHIFT +: DIV_Q_W];
    assign rem_full = biased - DIV_IN_W'(DIV_IN_W'(quot) * DIV_IN_W'(CAL_DIV));
    assign whole    = $signed({1'b0, quot}) - (DIV_Q_W+1)'(CAL_BIAS_Q);
    assign avg_wide = (BASE_W+3)'({whole, {CAL_FRAC_W{1'b0}}})
                    + (BASE_W+3)'(cal_frac(rem_full[REM_W-1:0]));
    assign avg      = $signed(avg_wide[BASE_W-1:0]);

endmodule
